### hdl/bis_pkg.sv
// bis_pkg: shared types and constants of the bicubic image scaler
// used by bis_div, bis_ctrl, bis_datapath and bicubic_image_scaler
package bis_pkg;

    // divider operand widths (dividend bits = iterations)
    localparam int DIV_N = 48;
    localparam int DIV_D = 38;

    // configuration register indexes
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_OUT_SIZE   = 2'd2;

    // input kind carried in tuser
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_RX,
        ST_DIV_RY,
        ST_SCALE,
        ST_SQUARE,
        ST_CUBE,
        ST_WEIGHT,
        ST_TAPS,
        ST_NORM,
        ST_DIV_Q,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        DSEL_RX,
        DSEL_RY,
        DSEL_Q
    } t_div_sel;

    // controller to datapath
    typedef struct packed {
        logic     load_wr;
        logic     req_capture;
        logic     div_start;
        t_div_sel div_sel;
        logic     rx_store;
        logic     ry_store;
        logic     scale_en;
        logic     square_en;
        logic     cube_en;
        logic     weight_en;
        logic     tap_issue;
        logic [3:0] tap_idx;
        logic     result_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

### hdl/bis_div.sv
// bis_div: restoring divider, one quotient bit per cycle
// depends on bis_pkg for operand widths
module bis_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bis_pkg::DIV_N-1:0]  i_dividend,
    input  logic [bis_pkg::DIV_D-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [bis_pkg::DIV_N-1:0]  o_quotient
);
    localparam int CW = $clog2(bis_pkg::DIV_N + 1);

    logic [CW-1:0]              r_cnt;
    logic [bis_pkg::DIV_N-1:0]  r_q;
    logic [bis_pkg::DIV_D-1:0]  r_rem;
    logic [bis_pkg::DIV_D-1:0]  r_div;
    logic [bis_pkg::DIV_D:0]    rem_sh;
    logic                       fits;

    // one trial subtract per step
    always_comb begin
        rem_sh = {r_rem, r_q[bis_pkg::DIV_N-1]};
        fits   = rem_sh >= {1'b0, r_div};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(bis_pkg::DIV_N);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[bis_pkg::DIV_N-2:0], fits};
            r_rem <= fits ? bis_pkg::DIV_D'(rem_sh - {1'b0, r_div})
                          : rem_sh[bis_pkg::DIV_D-1:0];
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_q;
endmodule

### hdl/bis_ctrl.sv
// bis_ctrl: sequencer of the scaler, one item at a time
// depends on bis_pkg for state, command and status types
module bis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tuser,
    output logic              o_s_tready,
    input  bis_pkg::t_status  i_status,
    output bis_pkg::t_cmd     o_cmd
);
    bis_pkg::t_state r_state, n_state;
    logic [4:0]      r_tap, n_tap;
    logic            accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bis_pkg::ST_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    assign o_s_tready = r_state == bis_pkg::ST_IDLE;
    assign accept     = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        o_cmd.div_sel = bis_pkg::DSEL_RX;
        o_cmd.tap_idx = r_tap[3:0];
        unique case (r_state)
            bis_pkg::ST_IDLE: begin
                if (accept && i_s_tuser == bis_pkg::MODE_LOAD) begin
                    o_cmd.load_wr = 1'b1;
                end else if (accept) begin
                    o_cmd.req_capture = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel     = bis_pkg::DSEL_RX;
                    n_state           = bis_pkg::ST_DIV_RX;
                end
            end
            bis_pkg::ST_DIV_RX: begin
                o_cmd.div_sel = bis_pkg::DSEL_RY;
                if (!i_status.div_busy) begin
                    o_cmd.rx_store  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = bis_pkg::ST_DIV_RY;
                end
            end
            bis_pkg::ST_DIV_RY: begin
                if (!i_status.div_busy) begin
                    o_cmd.ry_store = 1'b1;
                    n_state        = bis_pkg::ST_SCALE;
                end
            end
            bis_pkg::ST_SCALE: begin
                o_cmd.scale_en = 1'b1;
                n_state        = bis_pkg::ST_SQUARE;
            end
            bis_pkg::ST_SQUARE: begin
                o_cmd.square_en = 1'b1;
                n_state         = bis_pkg::ST_CUBE;
            end
            bis_pkg::ST_CUBE: begin
                o_cmd.cube_en = 1'b1;
                n_state       = bis_pkg::ST_WEIGHT;
            end
            bis_pkg::ST_WEIGHT: begin
                o_cmd.weight_en = 1'b1;
                n_tap           = '0;
                n_state         = bis_pkg::ST_TAPS;
            end
            bis_pkg::ST_TAPS: begin
                // last tap is summed in the cycle after its read
                if (r_tap[4]) begin
                    n_state = bis_pkg::ST_NORM;
                end else begin
                    o_cmd.tap_issue = 1'b1;
                    n_tap           = r_tap + 1'b1;
                end
            end
            bis_pkg::ST_NORM: begin
                o_cmd.div_sel   = bis_pkg::DSEL_Q;
                o_cmd.div_start = 1'b1;
                n_state         = bis_pkg::ST_DIV_Q;
            end
            bis_pkg::ST_DIV_Q: begin
                if (!i_status.div_busy) begin
                    n_state = bis_pkg::ST_DONE;
                end
            end
            bis_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = bis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bis_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

### hdl/bis_datapath.sv
// bis_datapath: config registers, frame store, kernel weights, accumulate, output register
// depends on bis_pkg and bis_div
module bis_datapath #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_OUT_SIZE   = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    input  logic [47:0]       i_s_tdata,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [31:0]       o_m_tdata,
    input  bis_pkg::t_cmd     i_cmd,
    output bis_pkg::t_status  o_status
);
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int AW = XW + YW;
    localparam int DN = bis_pkg::DIV_N;
    localparam int DD = bis_pkg::DIV_D;

    // configuration
    logic [9:0]  r_src_width, r_src_height;
    logic [10:0] r_out_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 10'd512;
            r_src_height <= 10'd512;
            r_out_size   <= 11'd512;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bis_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[9:0];
                bis_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[9:0];
                bis_pkg::CFG_OUT_SIZE:   r_out_size   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped extents, less one
    logic [9:0]  w_m1, h_m1;
    logic [10:0] n_m1;
    always_comb begin
        if (r_src_width == '0) w_m1 = '0;
        else if (32'(r_src_width) > MAX_SRC_WIDTH) w_m1 = 10'(MAX_SRC_WIDTH - 1);
        else w_m1 = r_src_width - 1'b1;
        if (r_src_height == '0) h_m1 = '0;
        else if (32'(r_src_height) > MAX_SRC_HEIGHT) h_m1 = 10'(MAX_SRC_HEIGHT - 1);
        else h_m1 = r_src_height - 1'b1;
        if (r_out_size == '0) n_m1 = '0;
        else if (32'(r_out_size) > MAX_OUT_SIZE) n_m1 = 11'(MAX_OUT_SIZE - 1);
        else n_m1 = r_out_size - 1'b1;
    end

    // input fields
    logic [8:0] in_src_x, in_src_y;
    logic [7:0] in_src_pixel;
    logic [9:0] in_out_x, in_out_y;
    assign in_src_x     = i_s_tdata[8:0];
    assign in_src_y     = i_s_tdata[17:9];
    assign in_src_pixel = i_s_tdata[25:18];
    assign in_out_x     = i_s_tdata[35:26];
    assign in_out_y     = i_s_tdata[45:36];

    // frame store, row-major by {row, column}
    logic [7:0]    r_mem [0:(2**AW)-1];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          ld_in_range;

    assign ld_in_range = (32'(in_src_x) < MAX_SRC_WIDTH) && (32'(in_src_y) < MAX_SRC_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && ld_in_range) begin
            r_mem[{YW'(in_src_y), XW'(in_src_x)}] <= in_src_pixel;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // shared divider
    logic [DN-1:0] div_dividend, div_q;
    logic [DD-1:0] div_divisor;
    logic          div_busy;

    bis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // request registers
    logic [9:0]  r_ox, r_oy;
    logic [25:0] r_rx, r_ry;
    logic [35:0] r_sx, r_sy;
    logic [31:0] r_d2x, r_d2y;
    logic [47:0] r_d3x, r_d3y;
    logic signed [15:0] r_wx [0:3];
    logic signed [15:0] r_wy [0:3];
    logic signed [31:0] r_wij;
    logic               r_tap_vld;
    logic signed [44:0] r_acc;
    logic signed [35:0] r_wsum;

    // accumulator magnitudes for the normalizing divide
    logic [44:0] na;
    logic [35:0] nw;
    always_comb begin
        na = r_acc[44]  ? 45'(-r_acc)  : 45'(r_acc);
        nw = r_wsum[35] ? 36'(-r_wsum) : 36'(r_wsum);
    end

    // divider operand select
    always_comb begin
        unique case (i_cmd.div_sel)
            bis_pkg::DSEL_RX: begin
                div_dividend = DN'({w_m1, 16'b0});
                div_divisor  = DD'(n_m1);
            end
            bis_pkg::DSEL_RY: begin
                div_dividend = DN'({h_m1, 16'b0});
                div_divisor  = DD'(n_m1);
            end
            bis_pkg::DSEL_Q: begin
                div_dividend = DN'({na, 1'b0}) + DN'(nw);
                div_divisor  = DD'({nw, 1'b0});
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    // round a 2^49-scaled weight to Q2.14, half away from zero
    function automatic logic signed [15:0] to_q14(input logic signed [52:0] v);
        logic [52:0] m;
        logic [52:0] r;
        m = v[52] ? 53'(-v) : 53'(v);
        r = (m + (53'd1 << 34)) >> 35;
        return v[52] ? -$signed(16'(r)) : $signed(16'(r));
    endfunction

    // Keys a=-0.5 weights for taps -1..+2
    function automatic logic [63:0] keys_weights(input logic [15:0] d,
                                                 input logic [31:0] d2,
                                                 input logic [47:0] d3);
        logic signed [52:0] sd, sd2, sd3;
        logic signed [52:0] v0, v1, v2, v3;
        sd  = $signed({37'b0, d});
        sd2 = $signed({21'b0, d2});
        sd3 = $signed({5'b0, d3});
        v0  = -(sd <<< 32) + (sd2 <<< 17) - sd3;
        v1  = (sd3 + (sd3 <<< 1)) - ((sd2 <<< 18) + (sd2 <<< 16)) + (53'sd1 <<< 49);
        v2  = (sd <<< 32) + (sd2 <<< 18) - (sd3 + (sd3 <<< 1));
        v3  = sd3 - (sd2 <<< 16);
        return {to_q14(v3), to_q14(v2), to_q14(v1), to_q14(v0)};
    endfunction

    // tap coordinate clamped to 0..lim
    function automatic logic [9:0] tap_coord(input logic [19:0] base,
                                             input logic [1:0]  off,
                                             input logic [9:0]  lim);
        logic [20:0] t;
        t = {1'b0, base} + 21'(off);
        if (t == '0) return '0;
        else if (t - 1'b1 > 21'(lim)) return lim;
        else return 10'(t - 1'b1);
    endfunction

    logic [63:0] wx_all, wy_all;
    assign wx_all = keys_weights(r_sx[15:0], r_d2x, r_d3x);
    assign wy_all = keys_weights(r_sy[15:0], r_d2y, r_d3y);

    // tap address
    logic [1:0] tap_i, tap_j;
    logic [9:0] tap_xx, tap_yy;
    assign tap_i   = i_cmd.tap_idx[1:0];
    assign tap_j   = i_cmd.tap_idx[3:2];
    assign tap_xx  = tap_coord(r_sx[35:16], tap_i, w_m1);
    assign tap_yy  = tap_coord(r_sy[35:16], tap_j, h_m1);
    assign rd_addr = {YW'(tap_yy), XW'(tap_xx)};

    // scale, weight and tap pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_capture) begin
            r_ox <= in_out_x;
            r_oy <= in_out_y;
        end
        if (i_cmd.rx_store) r_rx <= (n_m1 == '0) ? '0 : div_q[25:0];
        if (i_cmd.ry_store) r_ry <= (n_m1 == '0) ? '0 : div_q[25:0];
        if (i_cmd.scale_en) begin
            r_sx <= 36'(r_ox) * 36'(r_rx);
            r_sy <= 36'(r_oy) * 36'(r_ry);
        end
        if (i_cmd.square_en) begin
            r_d2x <= 32'(r_sx[15:0]) * 32'(r_sx[15:0]);
            r_d2y <= 32'(r_sy[15:0]) * 32'(r_sy[15:0]);
        end
        if (i_cmd.cube_en) begin
            r_d3x <= 48'(r_d2x) * 48'(r_sx[15:0]);
            r_d3y <= 48'(r_d2y) * 48'(r_sy[15:0]);
        end
        if (i_cmd.weight_en) begin
            for (int k = 0; k < 4; k++) begin
                r_wx[k] <= $signed(wx_all[16*k +: 16]);
                r_wy[k] <= $signed(wy_all[16*k +: 16]);
            end
        end
        if (i_cmd.tap_issue) begin
            r_wij <= r_wy[tap_j] * r_wx[tap_i];
        end
    end

    // multiply-accumulate, one tap per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld <= 1'b0;
        end else begin
            r_tap_vld <= i_cmd.tap_issue;
        end
        if (i_cmd.weight_en) begin
            r_acc  <= '0;
            r_wsum <= '0;
        end else if (r_tap_vld) begin
            r_acc  <= r_acc + 45'(r_wij * $signed({1'b0, r_rd_data}));
            r_wsum <= r_wsum + 36'(r_wij);
        end
    end

    // rounded, saturated result
    logic [7:0] pix;
    always_comb begin
        if (r_wsum == '0 || (r_acc[44] != r_wsum[35] && r_acc != '0)) pix = '0;
        else if (div_q > DN'(255)) pix = 8'd255;
        else pix = div_q[7:0];
    end

    // output register
    logic [31:0] r_out;
    logic        r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.result_load) begin
            r_out <= {4'b0, pix, r_oy, r_ox};
        end
    end

    assign o_m_tvalid        = r_out_vld;
    assign o_m_tdata         = r_out;
    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_vld || i_m_tready;
endmodule

### hdl/bicubic_image_scaler.sv
// a load is written into the frame store as it is accepted; a request holds the input until
// its result is loaded, through three passes of the 48-step divider (two ratios, one
// normalizing divide) and 16 frame store reads through the single read port
// one load per cycle while no request is in progress; the next item is taken while a result
// waits, a finished request waits only while the output register is full
// reset: synchronous, active low; config returns to 512/512/512, frame store is not cleared
module bicubic_image_scaler #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_OUT_SIZE   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_x[8:0], src_y[17:9], src_pixel[25:18], out_x[35:26], out_y[45:36]
    input  logic [47:0] s_axis_tdata,
    // mode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_x[9:0], result_y[19:10], result_pixel[27:20]
    output logic [31:0] m_axis_tdata
);
    bis_pkg::t_cmd    cmd;
    bis_pkg::t_status status;

    bis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bis_datapath #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_OUT_SIZE   (MAX_OUT_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

`ifndef SYNTHESIS
    // a load request frees the input again the next cycle
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == bis_pkg::MODE_LOAD
        |=> s_axis_tready)
        else $error("load did not complete in one cycle");

    // a pixel request blocks the input while it is worked on
    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == bis_pkg::MODE_REQUEST
        |=> !s_axis_tready)
        else $error("input taken during a pixel request");

    // the divider is never restarted while still iterating
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");
`endif
endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench of the bicubic image scaler
// depends on bis_pkg and bicubic_image_scaler; loads source pixels, requests outputs
`timescale 1ns / 100ps

module tb_top;

    localparam int STORE_W = 512;
    localparam int STORE_H = 512;
    localparam int OUT_MAX = 1024;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_ITEMS = 140;

    typedef struct packed {
        logic [9:0] px;
        logic [9:0] py;
        logic [7:0] pixel;
    } t_out_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // predictor state: shadow frame store and register copies
    logic [7:0]  shadow_store [STORE_W * STORE_H];
    logic [10:0] cfg_width = 11'd512;
    logic [10:0] cfg_height = 11'd512;
    logic [10:0] cfg_out = 11'd512;

    t_out_pixel  pending_pixels [$];
    int          err_count = 0;
    int          random_sent = 0;
    int          hold_off = 0;
    longint      cycle_count = 0;

    bicubic_image_scaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // random gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // weight rounded to signed Q2.14, half away from zero, from a 2^49 scale
    function automatic longint round_q14(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << 34)) >> 35;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // keys a=-0.5 tap weights from a Q0.16 fraction
    function automatic void keys_taps(input longint frac, output longint w [4]);
        longint d, d2, d3;
        d  = frac & 64'hFFFF;
        d2 = d * d;
        d3 = d2 * d;
        w[0] = round_q14(-d * 64'sd4294967296 + 2 * d2 * 65536 - d3);
        w[1] = round_q14(3 * d3 - 5 * d2 * 65536 + 2 * (64'sd1 <<< 48));
        w[2] = round_q14(d * 64'sd4294967296 + 4 * d2 * 65536 - 3 * d3);
        w[3] = round_q14(d3 - d2 * 65536);
    endfunction

    // interpolated output pixel for one request
    function automatic logic [7:0] bicubic_pixel(int ox, int oy);
        longint wd, ht, side, rx, ry, sx, sy, x0, y0, yy, xx, wij, acc, wsum;
        longint wx [4];
        longint wy [4];
        longint unsigned na, nw, q;
        logic neg;
        wd   = (cfg_width == 0) ? 1 : (cfg_width > STORE_W) ? STORE_W : cfg_width;
        ht   = (cfg_height == 0) ? 1 : (cfg_height > STORE_H) ? STORE_H : cfg_height;
        side = (cfg_out == 0) ? 1 : (cfg_out > OUT_MAX) ? OUT_MAX : cfg_out;
        rx = 0;
        ry = 0;
        if (side > 1) begin
            rx = ((wd - 1) <<< 16) / (side - 1);
            ry = ((ht - 1) <<< 16) / (side - 1);
        end
        sx = ox * rx;
        sy = oy * ry;
        x0 = sx >>> 16;
        y0 = sy >>> 16;
        keys_taps(sx, wx);
        keys_taps(sy, wy);
        acc = 0;
        wsum = 0;
        for (int j = 0; j < 4; j++) begin
            yy = y0 + j - 1;
            yy = (yy < 0) ? 0 : (yy > ht - 1) ? ht - 1 : yy;
            for (int i = 0; i < 4; i++) begin
                xx = x0 + i - 1;
                xx = (xx < 0) ? 0 : (xx > wd - 1) ? wd - 1 : xx;
                wij = wy[j] * wx[i];
                acc += wij * longint'(shadow_store[yy * STORE_W + xx]);
                wsum += wij;
            end
        end
        if (wsum == 0) return 8'd0;
        neg = (acc < 0) != (wsum < 0);
        na = (acc < 0) ? -acc : acc;
        nw = (wsum < 0) ? -wsum : wsum;
        q = (2 * na + nw) / (2 * nw);
        if (neg) return 8'd0;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // one item on the input stream; waits for acceptance, then updates the shadow store or predicts
    // valid stays up after acceptance so a following request can go back to back
    task automatic send_item(logic kind, logic [47:0] payload);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == bis_pkg::MODE_LOAD) begin
            shadow_store[payload[17:9] * STORE_W + payload[8:0]] = payload[25:18];
        end else begin
            pending_pixels.push_back({payload[35:26], payload[45:36],
                                      bicubic_pixel(payload[35:26], payload[45:36])});
        end
    endtask

    // drop valid before the input goes quiet
    task automatic idle_input();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic load_pixel(int x, int y, int value);
        logic [47:0] payload;
        payload = 48'({$urandom, $urandom});
        payload[47:46] = '0;
        payload[8:0] = 9'(x);
        payload[17:9] = 9'(y);
        payload[25:18] = 8'(value);
        send_item(bis_pkg::MODE_LOAD, payload);
    endtask

    task automatic request_pixel(int ox, int oy);
        logic [47:0] payload;
        payload = 48'({$urandom, $urandom});
        payload[47:46] = '0;
        payload[35:26] = 10'(ox);
        payload[45:36] = 10'(oy);
        send_item(bis_pkg::MODE_REQUEST, payload);
    endtask

    // wait for every result plus the tail of a load still in flight
    task automatic wait_idle();
        idle_input();
        wait (pending_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [10:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (index)
            bis_pkg::CFG_SRC_WIDTH:  cfg_width = value & 11'h3FF;
            bis_pkg::CFG_SRC_HEIGHT: cfg_height = value & 11'h3FF;
            bis_pkg::CFG_OUT_SIZE:   cfg_out = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(int wd, int ht, int side);
        wait_idle();
        write_reg(bis_pkg::CFG_SRC_WIDTH, 11'(wd));
        write_reg(bis_pkg::CFG_SRC_HEIGHT, 11'(ht));
        write_reg(bis_pkg::CFG_OUT_SIZE, 11'(side));
    endtask

    // fill the whole stored region with random or sharp-edged pixels
    task automatic fill_region(int wd, int ht, bit sharp);
        for (int y = 0; y < ht; y++)
            for (int x = 0; x < wd; x++)
                load_pixel(x, y, sharp ? (((x + y) % 2) ? 255 : 0) : $urandom_range(0, 255));
    endtask

    // small checkerboard: clamping, single output pixel, beyond-image requests
    task automatic test_directed();
        set_geometry(4, 4, 7);
        write_reg(CFG_UNUSED, 11'h7FF);
        fill_region(4, 4, 1'b1);
        request_pixel(0, 0);
        request_pixel(6, 6);
        request_pixel(3, 2);
        request_pixel(1023, 1023);
        request_pixel(1023, 0);
        set_geometry(4, 4, 1);
        request_pixel(5, 7);
        request_pixel(1023, 1023);
        // zero registers clamp to a single source pixel and one output pixel
        set_geometry(0, 0, 0);
        request_pixel(0, 0);
        request_pixel(600, 9);
        set_geometry(4, 4, 2047);
        request_pixel(1023, 1023);
        request_pixel(512, 0);
    endtask

    // widest row, oversized width register clamped
    task automatic test_wide_source();
        set_geometry(1023, 1, 1024);
        for (int x = 0; x < STORE_W; x++)
            load_pixel(x, 0, (x % 8 < 4) ? 255 : 0);
        request_pixel(0, 0);
        request_pixel(1023, 1023);
        request_pixel(511, 0);
        for (int i = 0; i < 6; i++) request_pixel($urandom_range(0, 1023), 0);
    endtask

    // single column, oversized output register clamped
    task automatic test_tall_source();
        set_geometry(1, 64, 2047);
        for (int y = 0; y < 64; y++)
            load_pixel(0, y, $urandom_range(0, 255));
        request_pixel(0, 1023);
        request_pixel(1023, 511);
        for (int i = 0; i < 6; i++) request_pixel(0, $urandom_range(0, 1023));
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        set_geometry(6, 5, 9);
        fill_region(6, 5, 1'b0);
        wait_idle();
        hold_off = 3000;
        for (int i = 0; i < 12; i++) request_pixel($urandom_range(0, 10), $urandom_range(0, 10));
    endtask

    // random geometries, each region filled, then mixed requests and reloads
    task automatic test_random();
        int wd, ht, side;
        while (random_sent < RANDOM_ITEMS) begin
            wd = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
            ht = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
            case ($urandom_range(0, 4))
                0: side = 1;
                1: side = $urandom_range(2, 4);
                2: side = $urandom_range(1000, 1024);
                default: side = $urandom_range(2, 40);
            endcase
            set_geometry(wd, ht, side);
            fill_region(wd, ht, $urandom_range(0, 3) == 0);
            random_sent += wd * ht;
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(0, 3) == 0)
                    load_pixel($urandom_range(0, wd - 1), $urandom_range(0, ht - 1),
                               $urandom_range(0, 255));
                else if ($urandom_range(0, 4) == 0)
                    request_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
                else
                    request_pixel($urandom_range(0, side), $urandom_range(0, side));
                random_sent++;
            end
        end
    endtask

    // receiver ready: random stalls, a forced hold-off when asked
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // compare each result with the oldest expected pixel
    always @(posedge i_clk) begin
        t_out_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result: tdata=%h", m_axis_tdata);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[9:0] !== want.px) begin
                    $error("result_x: expected %0d, got %0d", want.px, m_axis_tdata[9:0]);
                    err_count++;
                end
                if (m_axis_tdata[19:10] !== want.py) begin
                    $error("result_y: expected %0d, got %0d", want.py, m_axis_tdata[19:10]);
                    err_count++;
                end
                if (m_axis_tdata[27:20] !== want.pixel) begin
                    $error("result_pixel: expected %0d, got %0d",
                           want.pixel, m_axis_tdata[27:20]);
                    err_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_W * STORE_H; i++) shadow_store[i] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_wide_source();
        test_tall_source();
        test_output_stall();
        test_random();
        wait_idle();
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
